[design/mmm_pkg.sv]
// Shared types and constants for the modular matrix multiply block.
// Used by every module of the block but the RAM; depends on nothing else.
`timescale 1ns / 1ps

package mmm_pkg;

    // Largest matrix dimension held in the element stores.
    localparam int MAX_DIM = 64;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int KCNT_W  = $clog2(MAX_DIM + 1);

    // Field widths of the item and result payloads.
    localparam int OP_W    = 2;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 31;
    localparam int DIM_W   = 7;
    localparam int CIDX_W  = 2;
    localparam int PROD_W  = 2 * VAL_W;
    // A full dot product of MAX_DIM products never overflows this width.
    localparam int SUM_W   = PROD_W + $clog2(MAX_DIM);
    localparam int SCNT_W  = $clog2(SUM_W + 1);

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_COLS_B    = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_MODULUS   = 2'd3;

    localparam logic [DIM_W-1:0] ROWS_A_RESET  = 7'd64;
    localparam logic [DIM_W-1:0] INNER_RESET   = 7'd64;
    localparam logic [DIM_W-1:0] COLS_B_RESET  = 7'd64;
    localparam logic [VAL_W-1:0] MODULUS_RESET = 31'd1000000007;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic in_valid;
    } mac_ctrl_t;

    // Status from the reduction unit back to the sequencer.
    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] remainder;
    } mod_stat_t;

endpackage

[design/mmm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for both element stores.
`timescale 1ns / 1ps

module mmm_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/mmm_mac.sv]
// Multiply-accumulate unit: one registered 31x31 product per cycle added
// into a wide sum. Depends on mmm_pkg.
`timescale 1ns / 1ps

module mmm_mac
    import mmm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  mac_ctrl_t        ctrl,
    input  logic [VAL_W-1:0] a_data,
    input  logic [VAL_W-1:0] b_data,
    output logic             prod_vld,
    output logic [SUM_W-1:0] acc
);

    logic [PROD_W-1:0] prod_reg;
    logic              prod_vld_reg;
    logic [SUM_W-1:0]  acc_reg;

    // Product stage, registered before the add.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctrl.in_valid;
        end
        prod_reg <= PROD_W'(a_data) * PROD_W'(b_data);
    end

    // Accumulator stage; the sum is wide enough that no product can overflow it.
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end
    end

    assign prod_vld = prod_vld_reg;
    assign acc      = acc_reg;

endmodule

[design/mmm_mod.sv]
// Bit-serial reduction unit: the wide sum modulo the configured modulus,
// one dividend bit per cycle. Depends on mmm_pkg.
`timescale 1ns / 1ps

module mmm_mod
    import mmm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [VAL_W-1:0] modulus,
    output mod_stat_t        stat
);

    logic [SUM_W-1:0]  div_reg;
    logic [VAL_W-1:0]  rem_reg;
    logic [SCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [VAL_W:0]    trial;
    logic [VAL_W:0]    diff;

    // Shift the next dividend bit into the partial remainder and subtract once.
    always_comb begin
        trial = {rem_reg, div_reg[SUM_W-1]};
        diff  = trial - {1'b0, modulus};
    end

    // Control of the iteration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= SCNT_W'(SUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == SCNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath of the restoring reduction.
    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            div_reg <= {div_reg[SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, modulus}) begin
                rem_reg <= diff[VAL_W-1:0];
            end else begin
                rem_reg <= trial[VAL_W-1:0];
            end
        end
    end

    assign stat.done      = done_reg;
    assign stat.remainder = rem_reg;

    // The unit finishes only after a full pass over the dividend bits.
    a_done_after_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg) && $past(cnt_reg) == SCNT_W'(1))
        else $error("reduction finished early");

    a_start_clears_done: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !done_reg && busy_reg)
        else $error("reduction start did not restart the pass");

    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("reduction busy with an empty bit count");

endmodule

[design/modular_matrix_multiply.sv]
// Modular matrix multiply top level: element stores, sequencer, config
// registers and output register. Depends on mmm_pkg, mmm_ram, mmm_mac, mmm_mod.
// ---------------------------------------------------------------------------
// Usage: items arrive on the s_ channel. op 0 and op 1 write one element of
// matrix A or B; op 2 reads entry (row, col) of A*B modulo the modulus, which
// leaves one result item on the m_ channel. Writes and op 3 give no result.
// The cfg_ channel writes rows_a, inner_dim, cols_b and modulus by index; it
// is ready only while the block is idle and no input item is offered.
// A read walks the inner dimension on one shared multiply-accumulate unit,
// one product per cycle, then reduces the 68-bit sum in a bit-serial unit
// at one bit per cycle, and the block takes no item while a read is in
// progress. A read outside rows_a or cols_b answers on the next cycle with
// index_error set and a zero value.
// Reset (aresetn low, synchronous) returns the configuration to 64, 64, 64
// and 1000000007 and empties the output register; the element stores keep
// their contents and must be written before they are read.
// A stalled receiver holds the result in the output register; the block takes
// a new item only once that register is free or being emptied.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_matrix_multiply
    import mmm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [1:0] op, [7:2] row_index, [13:8] col_index, [44:14] element_value,
    // [47:45] zero.
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Result items.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [30:0] product_value, [31] index_error.
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [VAL_W-1:0]      cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RUN    = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_REDUCE = 3'd3;

    logic [2:0]           state_reg, state_next;
    logic [KCNT_W-1:0]    k_reg, k_next;
    logic [POS_W-1:0]     row_reg, row_next;
    logic [POS_W-1:0]     col_reg, col_next;
    logic                 issue_vld_reg, issue_vld_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [DIM_W-1:0]     rows_a_reg;
    logic [DIM_W-1:0]     inner_reg;
    logic [DIM_W-1:0]     cols_b_reg;
    logic [VAL_W-1:0]     modulus_reg;

    logic [OP_W-1:0]      in_op;
    logic [POS_W-1:0]     in_row;
    logic [POS_W-1:0]     in_col;
    logic [VAL_W-1:0]     in_value;
    logic                 accept;
    logic                 out_free;
    logic                 read_err;
    logic                 write_ok;
    logic [KCNT_W-1:0]    len;

    logic                 a_we, b_we;
    logic [ADDR_W-1:0]    waddr;
    logic [ADDR_W-1:0]    a_raddr, b_raddr;
    logic [VAL_W-1:0]     a_rdata, b_rdata;

    mac_ctrl_t            mac_ctrl;
    logic                 mac_prod_vld;
    logic [SUM_W-1:0]     mac_acc;
    logic                 mod_start;
    mod_stat_t            mod_stat;

    // Unpack the input item.
    assign in_op    = s_tdata[1:0];
    assign in_row   = s_tdata[7:2];
    assign in_col   = s_tdata[13:8];
    assign in_value = s_tdata[44:14];

    // A register write never lands on the edge that accepts an item, so an
    // item always sees one consistent configuration.
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign cfg_ready = (state_reg == ST_IDLE) && !s_tvalid;
    assign accept    = s_tvalid && s_tready;

    // Range checks and the saturated dot product length.
    assign read_err = (int'(in_row) >= int'(rows_a_reg)) || (int'(in_col) >= int'(cols_b_reg))
                   || (int'(in_row) >= MAX_DIM) || (int'(in_col) >= MAX_DIM);
    assign write_ok = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
    assign len      = (int'(inner_reg) > MAX_DIM) ? KCNT_W'(MAX_DIM) : KCNT_W'(inner_reg);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg  <= ROWS_A_RESET;
            inner_reg   <= INNER_RESET;
            cols_b_reg  <= COLS_B_RESET;
            modulus_reg <= MODULUS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ROWS_A:    rows_a_reg  <= cfg_data[DIM_W-1:0];
                CFG_INNER_DIM: inner_reg   <= cfg_data[DIM_W-1:0];
                CFG_COLS_B:    cols_b_reg  <= cfg_data[DIM_W-1:0];
                CFG_MODULUS:   modulus_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Element store addressing.
    assign a_we    = accept && (in_op == OP_WRITE_A) && write_ok;
    assign b_we    = accept && (in_op == OP_WRITE_B) && write_ok;
    assign waddr   = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);
    assign a_raddr = ADDR_W'(row_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(k_reg[IDX_W-1:0]);
    assign b_raddr = ADDR_W'(k_reg[IDX_W-1:0]) * ADDR_W'(MAX_DIM) + ADDR_W'(col_reg);

    mmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (in_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (in_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign mac_ctrl.clear    = accept && (in_op == OP_READ);
    assign mac_ctrl.in_valid = issue_vld_reg;

    mmm_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mac_ctrl),
        .a_data   (a_rdata),
        .b_data   (b_rdata),
        .prod_vld (mac_prod_vld),
        .acc      (mac_acc)
    );

    mmm_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (mac_acc),
        .modulus  (modulus_reg),
        .stat     (mod_stat)
    );

    // Sequencer: walk the inner dimension, drain the pipeline, then reduce.
    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        issue_vld_next = 1'b0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        mod_start      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (in_op == OP_READ)) begin
                    if (read_err) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = {1'b1, {VAL_W{1'b0}}};
                    end else begin
                        row_next   = in_row;
                        col_next   = in_col;
                        k_next     = '0;
                        state_next = (len == '0) ? ST_DRAIN : ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                issue_vld_next = 1'b1;
                k_next         = k_reg + 1'b1;
                if (k_next == len) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!issue_vld_reg && !mac_prod_vld) begin
                    mod_start  = 1'b1;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (mod_stat.done && out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, (modulus_reg == '0) ? {VAL_W{1'b0}}
                                                               : mod_stat.remainder};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_vld_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            k_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            issue_vld_reg <= issue_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
            k_reg         <= k_next;
        end
        row_reg     <= row_next;
        col_reg     <= col_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The reduction starts only on a fully accumulated sum.
    a_drained_start: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_start |-> !issue_vld_reg && !mac_prod_vld)
        else $error("reduction started with products in flight");

    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> k_reg < len)
        else $error("inner index ran past the dot product length");

    a_done_in_reduce: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mod_stat.done) |-> state_reg == ST_REDUCE)
        else $error("reduction finished outside the reduce phase");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[VAL_W] |-> m_tdata_reg[VAL_W-1:0] == '0)
        else $error("error result carries a nonzero value");

endmodule

[tb/mmm_product_checker.sv]
// Checker for the modular matrix multiply block: watches the item, result
// and configuration channels, predicts every read and compares the results.
// Depends on mmm_pkg for field widths, operation codes and register indexes.
`timescale 1ns / 1ps

module mmm_product_checker
    import mmm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [VAL_W-1:0]      cfg_data,
    output int                    mismatch_count,
    output int                    reads_in_flight
);

    localparam bit [63:0] SUM_CEILING = 64'd1 << 62;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             error;
    } entry_result_t;

    // Shadow copies of the element stores and the configuration.
    logic [VAL_W-1:0] a_elem [MAX_DIM][MAX_DIM];
    logic [VAL_W-1:0] b_elem [MAX_DIM][MAX_DIM];
    logic [DIM_W-1:0] rows_cfg;
    logic [DIM_W-1:0] inner_cfg;
    logic [DIM_W-1:0] cols_cfg;
    logic [VAL_W-1:0] modulus_cfg;

    // Product entries owed to the result channel, oldest first.
    entry_result_t awaited_entries [$];
    int            fail_total = 0;
    int            awaited_total = 0;

    assign mismatch_count  = fail_total;
    assign reads_in_flight = awaited_total;

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_total++;
    endtask

    // Dot product of row r of A and column c of B with the wide-sum reduction.
    function automatic entry_result_t product_entry(input logic [POS_W-1:0] r,
                                                    input logic [POS_W-1:0] c);
        entry_result_t res;
        int            len;
        bit [63:0]     acc;
        bit [63:0]     modw;
        res.value = '0;
        res.error = 1'b0;
        if (r >= rows_cfg || c >= cols_cfg) begin
            res.error = 1'b1;
            return res;
        end
        if (modulus_cfg == '0)
            return res;
        len  = (inner_cfg > MAX_DIM) ? MAX_DIM : int'(inner_cfg);
        modw = {33'd0, modulus_cfg};
        acc  = '0;
        for (int k = 0; k < len; k++) begin
            acc += {33'd0, a_elem[r][k]} * {33'd0, b_elem[k][c]};
            if (acc >= SUM_CEILING)
                acc = acc % modw;
        end
        acc = acc % modw;
        res.value = acc[VAL_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [VAL_W-1:0] val;
        entry_result_t    want;
        if (!aresetn) begin
            rows_cfg    = ROWS_A_RESET;
            inner_cfg   = INNER_RESET;
            cols_cfg    = COLS_B_RESET;
            modulus_cfg = MODULUS_RESET;
        end else begin
            // Results are matched before this edge's item is predicted, since
            // a read can never answer at the edge that accepts it.
            if (m_tvalid && m_tready) begin
                if (awaited_entries.size() == 0) begin
                    report($sformatf("result item 0x%08h with no read waiting", m_tdata));
                end else begin
                    want = awaited_entries.pop_front();
                    if (m_tdata[VAL_W-1:0] !== want.value)
                        report($sformatf("product_value %0d, expected %0d",
                                         m_tdata[VAL_W-1:0], want.value));
                    if (m_tdata[VAL_W] !== want.error)
                        report($sformatf("index_error %0b, expected %0b",
                                         m_tdata[VAL_W], want.error));
                end
            end

            // Register writes.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ROWS_A:    rows_cfg    = cfg_data[DIM_W-1:0];
                    CFG_INNER_DIM: inner_cfg   = cfg_data[DIM_W-1:0];
                    CFG_COLS_B:    cols_cfg    = cfg_data[DIM_W-1:0];
                    CFG_MODULUS:   modulus_cfg = cfg_data;
                    default: ;
                endcase
            end

            // Accepted input items update the stores or owe a result.
            if (s_tvalid && s_tready) begin
                op  = s_tdata[1:0];
                row = s_tdata[7:2];
                col = s_tdata[13:8];
                val = s_tdata[44:14];
                case (op)
                    OP_WRITE_A: a_elem[row][col] = val;
                    OP_WRITE_B: b_elem[row][col] = val;
                    OP_READ:    awaited_entries.push_back(product_entry(row, col));
                    default: ;
                endcase
            end
        end
        awaited_total = awaited_entries.size();
    end

endmodule

[tb/tb_modular_matrix_multiply.sv]
// Testbench top for the modular matrix multiply block: clock, reset, stimulus
// and final verdict. Depends on mmm_pkg, the block and mmm_product_checker.
`timescale 1ns / 1ps

module tb_modular_matrix_multiply;
    import mmm_pkg::*;

    localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;
    localparam logic [VAL_W-1:0] VALUE_MAX   = 31'h7FFFFFFF;
    localparam int               SETTLE      = 160;
    localparam int               CYCLE_LIMIT = 3000000;
    localparam int               RANDOM_GOAL = 1300;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CIDX_W-1:0]    cfg_index;
    logic [VAL_W-1:0]     cfg_data;
    int                   mismatch_count;
    int                   reads_in_flight;

    // Stimulus-side knowledge: current sizes and which elements hold data.
    int cur_rows;
    int cur_inner;
    int cur_cols;
    bit calm;
    bit a_filled [MAX_DIM][MAX_DIM];
    bit b_filled [MAX_DIM][MAX_DIM];
    int item_count;
    int cycle_count = 0;
    int stall_left;

    modular_matrix_multiply u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mmm_product_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .reads_in_flight (reads_in_flight)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("modular_matrix_multiply test failed");
            $finish;
        end
    end

    // Idle length for either side: mostly none or short, a few long.
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (p < 55)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VAL_W-1:0] element_pick();
        int p;
        p = $urandom_range(0, 9);
        if (p < 3)
            return VAL_W'(VALUE_MAX - $urandom_range(0, 3));
        if (p < 5)
            return VAL_W'($urandom_range(0, 15));
        return VAL_W'($urandom);
    endfunction

    // Receiver: random stalls on the result channel.
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready   = 1'b1;
                stall_left = idle_len();
            end
        end
    end

    // Offer one item and hold it until the block takes it. Valid is left high
    // so that a following item with no gap keeps it up.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] r,
                             input logic [POS_W-1:0] c, input logic [VAL_W-1:0] v);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, v, c, r, op};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (op == OP_WRITE_A)
            a_filled[r][c] = 1'b1;
        if (op == OP_WRITE_B)
            b_filled[r][c] = 1'b1;
        if (op != OP_UNUSED)
            item_count++;
    endtask

    // Stop sending and wait until every read has answered and the block is
    // surely back to idle.
    task automatic drain();
        s_tvalid = 1'b0;
        @(negedge aclk);
        while (reads_in_flight != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input int rows, input int inner, input int cols,
                              input logic [VAL_W-1:0] modv);
        drain();
        write_reg(CFG_ROWS_A, VAL_W'(rows[DIM_W-1:0]));
        write_reg(CFG_INNER_DIM, VAL_W'(inner[DIM_W-1:0]));
        write_reg(CFG_COLS_B, VAL_W'(cols[DIM_W-1:0]));
        write_reg(CFG_MODULUS, modv);
        cur_rows  = rows;
        cur_inner = inner;
        cur_cols  = cols;
    endtask

    // Read one product entry, first filling any element it would touch.
    task automatic read_entry(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
        int len;
        len = (cur_inner > MAX_DIM) ? MAX_DIM : cur_inner;
        if (r < cur_rows && c < cur_cols) begin
            for (int k = 0; k < len; k++) begin
                if (!a_filled[r][k])
                    send_item(OP_WRITE_A, r, POS_W'(k), element_pick());
                if (!b_filled[k][c])
                    send_item(OP_WRITE_B, POS_W'(k), c, element_pick());
            end
        end
        send_item(OP_READ, r, c, element_pick());
    endtask

    function automatic int dim_pick();
        int p;
        p = $urandom_range(0, 99);
        if (p < 25)
            return MAX_DIM;
        if (p < 35)
            return 1;
        if (p < 38)
            return 0;
        if (p < 42)
            return $urandom_range(MAX_DIM + 1, 127);
        return $urandom_range(1, MAX_DIM);
    endfunction

    function automatic int inner_pick();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return $urandom_range(1, 8);
        if (p < 75)
            return $urandom_range(9, 24);
        if (p < 85)
            return $urandom_range(25, MAX_DIM);
        if (p < 90)
            return $urandom_range(MAX_DIM + 1, 127);
        if (p < 95)
            return 0;
        return MAX_DIM;
    endfunction

    function automatic logic [VAL_W-1:0] modulus_pick();
        int p;
        p = $urandom_range(0, 99);
        if (p < 15)
            return VALUE_MAX;
        if (p < 25)
            return VAL_W'($urandom_range(1, 3));
        if (p < 30)
            return '0;
        if (p < 50)
            return VAL_W'($urandom_range(2, 1000));
        return VAL_W'($urandom);
    endfunction

    // One random step: mostly reads with their operands in place, some
    // stray writes, out-of-range reads, unused opcodes and full drains.
    task automatic random_item();
        int               p;
        int               len;
        int               k;
        int               rows_eff;
        int               cols_eff;
        logic [POS_W-1:0] r;
        logic [POS_W-1:0] c;
        p        = $urandom_range(0, 99);
        rows_eff = (cur_rows > MAX_DIM) ? MAX_DIM : cur_rows;
        cols_eff = (cur_cols > MAX_DIM) ? MAX_DIM : cur_cols;
        len      = (cur_inner > MAX_DIM) ? MAX_DIM : cur_inner;
        if (p < 2) begin
            drain();
        end else if (p < 5) begin
            send_item(OP_UNUSED, POS_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
        end else if (p < 25) begin
            send_item($urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A,
                      POS_W'($urandom), POS_W'($urandom), element_pick());
        end else if (p < 32 || rows_eff == 0 || cols_eff == 0) begin
            // Read outside the product size where the sizes leave room.
            r = POS_W'($urandom);
            c = POS_W'($urandom);
            if (rows_eff < MAX_DIM && (cols_eff == MAX_DIM || $urandom_range(0, 1)))
                r = POS_W'($urandom_range(rows_eff, MAX_DIM - 1));
            else if (cols_eff < MAX_DIM)
                c = POS_W'($urandom_range(cols_eff, MAX_DIM - 1));
            read_entry(r, c);
        end else begin
            r = POS_W'($urandom_range(0, rows_eff - 1));
            c = POS_W'($urandom_range(0, cols_eff - 1));
            if (len > 0 && $urandom_range(0, 9) < 3) begin
                k = $urandom_range(0, len - 1);
                if ($urandom_range(0, 1))
                    send_item(OP_WRITE_A, r, POS_W'(k), element_pick());
                else
                    send_item(OP_WRITE_B, POS_W'(k), c, element_pick());
            end
            read_entry(r, c);
        end
    endtask

    initial begin
        int goal;
        int n;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        calm       = 1'b0;
        item_count = 0;
        cur_rows   = ROWS_A_RESET;
        cur_inner  = INNER_RESET;
        cur_cols   = COLS_B_RESET;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: wide sums that cross the reduction threshold.
        set_config(2, 2, 2, VALUE_MAX);
        send_item(OP_WRITE_A, 0, 0, VALUE_MAX);
        send_item(OP_WRITE_A, 0, 1, VALUE_MAX);
        send_item(OP_WRITE_B, 0, 0, VALUE_MAX);
        send_item(OP_WRITE_B, 1, 0, VALUE_MAX);
        send_item(OP_READ, 0, 0, '0);
        send_item(OP_WRITE_A, 1, 0, '0);
        send_item(OP_WRITE_A, 1, 1, '0);
        send_item(OP_WRITE_B, 0, 1, '0);
        send_item(OP_WRITE_B, 1, 1, 31'd1);
        send_item(OP_READ, 1, 1, VALUE_MAX);
        send_item(OP_READ, 0, 1, '0);
        // Reads past the row and column limits.
        send_item(OP_READ, 2, 0, '0);
        send_item(OP_READ, 0, 2, '0);
        send_item(OP_READ, 63, 63, '0);
        // Unused opcode with every row, column and value bit set.
        send_item(OP_UNUSED, 6'h3F, 6'h3F, VALUE_MAX);
        // Writes are not limited by the configured sizes.
        send_item(OP_WRITE_A, 63, 63, VALUE_MAX);
        send_item(OP_WRITE_B, 63, 63, 31'h2AAAAAAA);
        send_item(OP_READ, 0, 0, '0);

        // Zero modulus, zero inner length, modulus one, no rows at all.
        set_config(2, 2, 2, '0);
        send_item(OP_READ, 0, 0, '0);
        set_config(2, 0, 2, 31'd12345);
        send_item(OP_READ, 1, 1, '0);
        set_config(2, 2, 2, 31'd1);
        send_item(OP_READ, 0, 0, '0);
        set_config(0, 2, 127, VALUE_MAX);
        send_item(OP_READ, 0, 0, '0);

        // Inner length above the store size saturates at the full width.
        set_config(127, 127, MAX_DIM, VALUE_MAX);
        calm = 1'b1;
        read_entry(63, 63);
        calm = 1'b0;

        // Random phases, each with its own configuration.
        goal = item_count + RANDOM_GOAL;
        while (item_count < goal) begin
            set_config(dim_pick(), inner_pick(), dim_pick(), modulus_pick());
            calm = ($urandom_range(0, 4) == 0);
            n = $urandom_range(60, 160);
            for (int i = 0; i < n && item_count < goal; i++)
                random_item();
        end
        calm = 1'b0;

        drain();
        if (mismatch_count == 0)
            $display("modular_matrix_multiply test passed");
        else
            $display("modular_matrix_multiply test failed");
        $finish;
    end

endmodule

[filelist.f]
design/mmm_pkg.sv
design/mmm_ram.sv
design/mmm_mac.sv
design/mmm_mod.sv
design/modular_matrix_multiply.sv
tb/mmm_product_checker.sv
tb/tb_modular_matrix_multiply.sv
